/* rtl/core/pws_pkg.sv */
`timescale 1ns / 1ps
package pws_pkg;

    localparam int WINDOW_DEPTH  = 64;
    localparam int VALUE_BITS    = 20;
    localparam int POSITION_BITS = 31;
    localparam int SPAN_BITS     = 16;
    localparam int HALF_BITS     = SPAN_BITS - 1;
    localparam int IDX_BITS      = $clog2(WINDOW_DEPTH);
    localparam int CNT_BITS      = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_BITS      = VALUE_BITS + CNT_BITS;
    localparam int DIVIDEND_BITS = SUM_BITS + 1;
    localparam int DIVISOR_BITS  = CNT_BITS + 1;
    localparam int STEP_BITS     = $clog2(DIVIDEND_BITS + 1);
    localparam int ENTRY_BITS    = 1 + VALUE_BITS + POSITION_BITS;
    localparam logic [SPAN_BITS-1:0] SPAN_RESET = SPAN_BITS'(500);

    typedef struct packed {
        logic [POSITION_BITS-1:0] position;
        logic [VALUE_BITS-1:0]    value;
        logic                     present;
        logic                     last;
        logic [HALF_BITS-1:0]     half;
        logic                     bypass;
    } pws_item_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic                  present;
        logic                  truncated;
        logic                  run_last;
    } pws_result_t;

    typedef struct packed {
        logic [CNT_BITS-1:0] held;
        logic [CNT_BITS-1:0] waiting;
        logic                idle;
    } pws_status_t;

endpackage

/* rtl/core/position_window_smoother_top.sv */
`timescale 1ns / 1ps
// Moving average over sorted genomic sites: each site with a value yields the
// rounded-half-up mean of all present values within span_bp / 2 of it, in input
// order, once a later site lies beyond its window, series_end is seen or the
// site store fills with waiting sites; a site without a value yields a result
// with smoothed_present low, and a span of zero passes items straight through.
// A two-word input queue decouples the port from the sequencer, which handles
// one word at a time, evicting the oldest site when the store is full and
// retiring sites out of range; each result scans the held sites through
// the single read port of the 64-entry site store, then a bit-serial divider.
// Results leave through one output register, so one result may wait while the
// next word is taken in. The site store needs no clearing after reset.
module position_window_smoother_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                span_we,
    input  logic [pws_pkg::SPAN_BITS-1:0]       span_bp,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [pws_pkg::POSITION_BITS-1:0]   site_position,
    input  logic [pws_pkg::VALUE_BITS-1:0]      site_value,
    input  logic                                value_present,
    input  logic                                series_end,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [pws_pkg::VALUE_BITS-1:0]      smoothed_value,
    output logic                                smoothed_present,
    output logic                                window_truncated,
    output logic                                run_last
);

    logic [pws_pkg::SPAN_BITS-1:0]  span_reg;
    logic                           q_valid;
    logic                           q_pop;
    pws_pkg::pws_item_t             q_item;
    logic                           res_valid;
    logic                           res_ready;
    pws_pkg::pws_result_t           res;
    pws_pkg::pws_status_t           status;
    logic                           out_valid_reg;
    pws_pkg::pws_result_t           out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            span_reg <= pws_pkg::SPAN_RESET;
        end
        else if (span_we)
        begin
            span_reg <= span_bp;
        end
    end

    pws_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .site_position(site_position),
        .site_value   (site_value),
        .value_present(value_present),
        .series_end   (series_end),
        .span         (span_reg),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop)
    );

    pws_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .res_valid(res_valid),
        .res      (res),
        .res_ready(res_ready),
        .status   (status)
    );

    assign res_ready = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid        = out_valid_reg;
    assign smoothed_value   = out_reg.value;
    assign smoothed_present = out_reg.present;
    assign window_truncated = out_reg.truncated;
    assign run_last         = out_reg.run_last;

    a_waiting_held: assert property (@(posedge clk) disable iff (!rst_n)
        status.waiting <= status.held)
        else $error("more sites waiting than held");

    a_held_depth: assert property (@(posedge clk) disable iff (!rst_n)
        status.held <= pws_pkg::CNT_BITS'(pws_pkg::WINDOW_DEPTH))
        else $error("site store overfilled");

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !status.idle)
        else $error("result offered while sequencer idle");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> !status.idle)
        else $error("sequencer did not start on a popped word");

endmodule

/* rtl/core/pws_ram.sv */
`timescale 1ns / 1ps
module pws_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/pws_div.sv */
`timescale 1ns / 1ps
module pws_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [pws_pkg::DIVIDEND_BITS-1:0]   dividend,
    input  logic [pws_pkg::DIVISOR_BITS-1:0]    divisor,
    output logic                                done,
    output logic [pws_pkg::DIVIDEND_BITS-1:0]   quotient
);

    logic                               busy_reg;
    logic                               done_reg;
    logic [pws_pkg::STEP_BITS-1:0]      step_reg;
    logic [pws_pkg::DIVISOR_BITS-1:0]   rem_reg;
    logic [pws_pkg::DIVISOR_BITS-1:0]   dsr_reg;
    logic [pws_pkg::DIVIDEND_BITS-1:0]  quo_reg;
    logic [pws_pkg::DIVISOR_BITS:0]     shifted;
    logic [pws_pkg::DIVISOR_BITS:0]     diff;
    logic                               fits;

    assign shifted = {rem_reg, quo_reg[pws_pkg::DIVIDEND_BITS-1]};
    assign diff    = shifted - {1'b0, dsr_reg};
    assign fits    = shifted >= {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
                rem_reg  <= '0;
                dsr_reg  <= divisor;
                quo_reg  <= dividend;
            end
            else if (busy_reg)
            begin
                rem_reg  <= fits ? diff[pws_pkg::DIVISOR_BITS-1:0]
                                 : shifted[pws_pkg::DIVISOR_BITS-1:0];
                quo_reg  <= {quo_reg[pws_pkg::DIVIDEND_BITS-2:0], fits};
                step_reg <= step_reg + 1'b1;
                if (step_reg == pws_pkg::STEP_BITS'(pws_pkg::DIVIDEND_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* rtl/core/pws_front.sv */
`timescale 1ns / 1ps
module pws_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [pws_pkg::POSITION_BITS-1:0]   site_position,
    input  logic [pws_pkg::VALUE_BITS-1:0]      site_value,
    input  logic                                value_present,
    input  logic                                series_end,
    input  logic [pws_pkg::SPAN_BITS-1:0]       span,
    output logic                                q_valid,
    output pws_pkg::pws_item_t                  q_item,
    input  logic                                q_pop
);

    pws_pkg::pws_item_t slot_reg [2];
    logic               wr_ptr_reg;
    logic               rd_ptr_reg;
    logic [1:0]         count_reg;
    logic               push;
    pws_pkg::pws_item_t item;

    assign in_stall = count_reg == 2'd2;
    assign push     = in_valid && !in_stall;
    assign q_valid  = count_reg != 2'd0;
    assign q_item   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        item.position = site_position;
        item.value    = site_value;
        item.present  = value_present;
        item.last     = series_end;
        item.half     = span[pws_pkg::SPAN_BITS-1:1];
        item.bypass   = span == '0;
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end

endmodule

/* rtl/core/pws_back.sv */
`timescale 1ns / 1ps
module pws_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    input  pws_pkg::pws_item_t          q_item,
    output logic                        q_pop,
    output logic                        res_valid,
    output pws_pkg::pws_result_t        res,
    input  logic                        res_ready,
    output pws_pkg::pws_status_t        status
);

    typedef enum logic [4:0] {
        S_IDLE, S_EVICT_RD, S_EVICT, S_WRITE, S_ADV, S_ADV_CHK, S_HEAD, S_FHEAD,
        S_SCAN, S_DIVGO, S_DIVW, S_PUT, S_RET, S_RET_CHK, S_TAIL, S_FLUSH,
        S_BYP, S_LAST
    } state_t;

    localparam logic [pws_pkg::CNT_BITS-1:0] FULL = pws_pkg::CNT_BITS'(pws_pkg::WINDOW_DEPTH);

    state_t                              state_reg;
    state_t                              ret_reg;
    pws_pkg::pws_item_t                  item_reg;
    logic [pws_pkg::IDX_BITS-1:0]        oldest_reg;
    logic [pws_pkg::IDX_BITS-1:0]        pend_reg;
    logic [pws_pkg::IDX_BITS-1:0]        newest_reg;
    logic [pws_pkg::IDX_BITS-1:0]        k_reg;
    logic [pws_pkg::CNT_BITS-1:0]        held_reg;
    logic [pws_pkg::CNT_BITS-1:0]        pcnt_reg;
    logic [pws_pkg::CNT_BITS-1:0]        issued_reg;
    logic [pws_pkg::CNT_BITS-1:0]        cnt_reg;
    logic [pws_pkg::SUM_BITS-1:0]        sum_reg;
    logic                                dv_reg;
    logic                                forced_reg;
    logic                                trunc_reg;
    logic                                drop_v_reg;
    logic [pws_pkg::POSITION_BITS-1:0]   drop_pos_reg;
    logic [pws_pkg::POSITION_BITS-1:0]   c_reg;
    logic [pws_pkg::POSITION_BITS-1:0]   ref_reg;
    logic                                hv_reg;
    pws_pkg::pws_result_t                hold_reg;
    pws_pkg::pws_result_t                new_reg;

    logic [pws_pkg::IDX_BITS-1:0]        raddr;
    logic [pws_pkg::ENTRY_BITS-1:0]      rdata;
    logic                                rd_present;
    logic [pws_pkg::VALUE_BITS-1:0]      rd_value;
    logic [pws_pkg::POSITION_BITS-1:0]   rd_pos;
    logic [pws_pkg::POSITION_BITS:0]     half_x;
    logic                                div_start;
    logic                                div_done;
    logic [pws_pkg::DIVIDEND_BITS-1:0]   quotient;
    logic                                rd_in;
    logic                                drop_in;

    function automatic logic [pws_pkg::IDX_BITS-1:0] nxt(input logic [pws_pkg::IDX_BITS-1:0] i);
        return (i == pws_pkg::IDX_BITS'(pws_pkg::WINDOW_DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    function automatic logic in_win(input logic [pws_pkg::POSITION_BITS-1:0] p,
                                    input logic [pws_pkg::POSITION_BITS-1:0] c,
                                    input logic [pws_pkg::POSITION_BITS:0] h);
        return ({1'b0, p} + h >= {1'b0, c}) && ({1'b0, p} <= {1'b0, c} + h);
    endfunction

    assign {rd_present, rd_value, rd_pos} = rdata;
    assign half_x  = {{(pws_pkg::POSITION_BITS + 1 - pws_pkg::HALF_BITS){1'b0}}, item_reg.half};
    assign rd_in   = rd_present && in_win(rd_pos, c_reg, half_x);
    assign drop_in = drop_v_reg && in_win(drop_pos_reg, c_reg, half_x);

    always_comb
    begin
        case (state_reg)
            S_EVICT_RD, S_RET: raddr = oldest_reg;
            S_SCAN:            raddr = k_reg;
            default:           raddr = pend_reg;
        endcase
    end

    pws_ram #(
        .WIDTH(pws_pkg::ENTRY_BITS),
        .DEPTH(pws_pkg::WINDOW_DEPTH)
    ) u_store (
        .clk  (clk),
        .we   (state_reg == S_WRITE),
        .waddr(newest_reg),
        .wdata({item_reg.present, item_reg.value, item_reg.position}),
        .raddr(raddr),
        .rdata(rdata)
    );

    assign div_start = state_reg == S_DIVGO;

    pws_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .dividend({sum_reg, 1'b0} + pws_pkg::DIVIDEND_BITS'(cnt_reg)),
        .divisor ({cnt_reg, 1'b0}),
        .done    (div_done),
        .quotient(quotient)
    );

    assign q_pop     = state_reg == S_IDLE && q_valid;
    assign res_valid = hv_reg && (state_reg == S_PUT || state_reg == S_BYP
                                  || state_reg == S_LAST);
    always_comb
    begin
        res          = hold_reg;
        res.run_last = state_reg == S_LAST;
    end

    assign status.held    = held_reg;
    assign status.waiting = pcnt_reg;
    assign status.idle    = state_reg == S_IDLE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            ret_reg      <= S_IDLE;
            oldest_reg   <= '0;
            pend_reg     <= '0;
            newest_reg   <= '0;
            held_reg     <= '0;
            pcnt_reg     <= '0;
            issued_reg   <= '0;
            dv_reg       <= 1'b0;
            forced_reg   <= 1'b0;
            drop_v_reg   <= 1'b0;
            drop_pos_reg <= '0;
            hv_reg       <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        item_reg   <= q_item;
                        forced_reg <= 1'b0;
                        if (q_item.bypass)
                        begin
                            state_reg <= S_FLUSH;
                        end
                        else if (held_reg == FULL)
                        begin
                            state_reg <= S_EVICT_RD;
                        end
                        else
                        begin
                            state_reg <= S_WRITE;
                        end
                    end
                end
                S_EVICT_RD:
                begin
                    state_reg <= S_EVICT;
                end
                S_EVICT:
                begin
                    if (rd_present)
                    begin
                        drop_v_reg   <= 1'b1;
                        drop_pos_reg <= rd_pos;
                    end
                    oldest_reg <= nxt(oldest_reg);
                    held_reg   <= held_reg - 1'b1;
                    state_reg  <= S_WRITE;
                end
                S_WRITE:
                begin
                    newest_reg <= nxt(newest_reg);
                    held_reg   <= held_reg + 1'b1;
                    pcnt_reg   <= pcnt_reg + 1'b1;
                    state_reg  <= S_ADV;
                end
                S_ADV:
                begin
                    if (pcnt_reg == '0)
                    begin
                        ref_reg   <= item_reg.position;
                        state_reg <= S_RET;
                    end
                    else
                    begin
                        state_reg <= S_ADV_CHK;
                    end
                end
                S_ADV_CHK:
                begin
                    if (rd_present && ({1'b0, item_reg.position} <= {1'b0, rd_pos} + half_x))
                    begin
                        ref_reg   <= rd_pos;
                        state_reg <= S_RET;
                    end
                    else
                    begin
                        ret_reg   <= S_ADV;
                        state_reg <= S_HEAD;
                    end
                end
                S_FHEAD:
                begin
                    state_reg <= S_HEAD;
                end
                S_HEAD:
                begin
                    c_reg <= rd_pos;
                    if (!rd_present)
                    begin
                        new_reg   <= '0;
                        state_reg <= S_PUT;
                    end
                    else
                    begin
                        sum_reg    <= '0;
                        cnt_reg    <= '0;
                        k_reg      <= oldest_reg;
                        issued_reg <= '0;
                        dv_reg     <= 1'b0;
                        state_reg  <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    dv_reg <= issued_reg < held_reg;
                    if (issued_reg < held_reg)
                    begin
                        k_reg      <= nxt(k_reg);
                        issued_reg <= issued_reg + 1'b1;
                    end
                    if (dv_reg && rd_in)
                    begin
                        sum_reg <= sum_reg + pws_pkg::SUM_BITS'(rd_value);
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    if (issued_reg == held_reg && !dv_reg)
                    begin
                        state_reg <= S_DIVGO;
                    end
                end
                S_DIVGO:
                begin
                    trunc_reg <= forced_reg || drop_in;
                    state_reg <= S_DIVW;
                end
                S_DIVW:
                begin
                    if (div_done)
                    begin
                        new_reg.value     <= quotient[pws_pkg::VALUE_BITS-1:0];
                        new_reg.present   <= 1'b1;
                        new_reg.truncated <= trunc_reg;
                        new_reg.run_last  <= 1'b0;
                        state_reg         <= S_PUT;
                    end
                end
                S_PUT:
                begin
                    if (!hv_reg || res_ready)
                    begin
                        hold_reg   <= new_reg;
                        hv_reg     <= 1'b1;
                        pend_reg   <= nxt(pend_reg);
                        pcnt_reg   <= pcnt_reg - 1'b1;
                        forced_reg <= 1'b0;
                        state_reg  <= ret_reg;
                    end
                end
                S_RET:
                begin
                    state_reg <= (held_reg > pcnt_reg) ? S_RET_CHK : S_TAIL;
                end
                S_RET_CHK:
                begin
                    if ({1'b0, rd_pos} + half_x < {1'b0, ref_reg})
                    begin
                        oldest_reg <= nxt(oldest_reg);
                        held_reg   <= held_reg - 1'b1;
                        state_reg  <= S_RET;
                    end
                    else
                    begin
                        state_reg <= S_TAIL;
                    end
                end
                S_TAIL:
                begin
                    if (item_reg.last)
                    begin
                        state_reg <= S_FLUSH;
                    end
                    else if (pcnt_reg >= FULL)
                    begin
                        forced_reg <= 1'b1;
                        ret_reg    <= S_LAST;
                        state_reg  <= S_FHEAD;
                    end
                    else
                    begin
                        state_reg <= S_LAST;
                    end
                end
                S_FLUSH:
                begin
                    if (pcnt_reg != '0)
                    begin
                        ret_reg   <= S_FLUSH;
                        state_reg <= S_FHEAD;
                    end
                    else
                    begin
                        oldest_reg   <= newest_reg;
                        pend_reg     <= newest_reg;
                        held_reg     <= '0;
                        drop_v_reg   <= 1'b0;
                        drop_pos_reg <= '0;
                        state_reg    <= item_reg.bypass ? S_BYP : S_LAST;
                    end
                end
                S_BYP:
                begin
                    if (!hv_reg || res_ready)
                    begin
                        hold_reg.value     <= item_reg.present ? item_reg.value : '0;
                        hold_reg.present   <= item_reg.present;
                        hold_reg.truncated <= 1'b0;
                        hold_reg.run_last  <= 1'b0;
                        hv_reg             <= 1'b1;
                        state_reg          <= S_LAST;
                    end
                end
                S_LAST:
                begin
                    if (!hv_reg || res_ready)
                    begin
                        hv_reg    <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
